FILE: src/afc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg
// Shared widths, result codes and binary64 helpers for the compare unit.
// ----------------------------------------------------------------------------
package afc_pkg;

   localparam int unsigned WordWidth    = 64;
   localparam int unsigned ExpWidth     = 11;
   localparam int unsigned FracWidth    = 52;
   localparam int unsigned CsrAddrWidth = 4;

   localparam logic [WordWidth-1:0] ToleranceReset = 64'h3CB0_0000_0000_0000;
   localparam logic [WordWidth-1:0] QuietNan       = 64'h7FF8_0000_0000_0000;

   // register index, taken from paddr[3] (8-byte registers)
   localparam logic RegTolerance = 1'b0;

   localparam logic signed [1:0] OrderGreater = 2'sb01;
   localparam logic signed [1:0] OrderLess    = 2'sb11;
   localparam logic signed [1:0] OrderEqual   = 2'sb00;

   function automatic logic f64_is_nan(input logic [WordWidth-1:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
   endfunction

   function automatic logic f64_is_inf(input logic [WordWidth-1:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
   endfunction

   function automatic logic f64_is_zero(input logic [WordWidth-1:0] v);
      return v[62:0] == 63'd0;
   endfunction

   // monotonic unsigned key for ordered (non-NaN) values
   function automatic logic [WordWidth-1:0] f64_order_key(input logic [WordWidth-1:0] v);
      return v[63] ? ~v : {1'b1, v[62:0]};
   endfunction

endpackage

FILE: src/afc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_if
// Valid/ready channels for operand pairs and compare results.
// ----------------------------------------------------------------------------
interface afc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] first_value;
   logic [63:0] second_value;

   modport source (output valid, first_value, second_value, input ready);
   modport sink   (input valid, first_value, second_value, output ready);
endinterface

interface afc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] order;

   modport source (output valid, order, input ready);
   modport sink   (input valid, order, output ready);
endinterface

FILE: src/afc_sub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_sub
// Four-stage binary64 subtractor, round to nearest even.
// ----------------------------------------------------------------------------
module afc_sub
   import afc_pkg::*;
(
   input  logic                 clock,
   input  logic                 advance,
   input  logic [WordWidth-1:0] a,
   input  logic [WordWidth-1:0] b,
   output logic [WordWidth-1:0] diff
);

   function automatic logic [5:0] lead_zeros56(input logic [55:0] v);
      logic [5:0] n;
      n = 6'd56;
      for (int i = 0; i < 56; i++) begin
         if (v[i]) n = 6'(55 - i);
      end
      return n;
   endfunction

   // stage 1: unpack, order by magnitude
   logic [WordWidth-1:0] y_bits, x_bits, w_bits;
   logic                 swap;
   logic [10:0]          ex, ew;
   logic                 s1_sign_in, s1_sub_in, s1_nan_in, s1_inf_in, s1_isign_in;
   logic [10:0]          s1_exp_in, s1_dexp_in;
   logic [52:0]          s1_sigx_in, s1_sigy_in;

   logic                 s1_sign_ff, s1_sub_ff, s1_nan_ff, s1_inf_ff, s1_isign_ff;
   logic [10:0]          s1_exp_ff, s1_dexp_ff;
   logic [52:0]          s1_sigx_ff, s1_sigy_ff;

   always_comb begin
      y_bits      = {~b[63], b[62:0]};
      swap        = b[62:0] > a[62:0];
      x_bits      = swap ? y_bits : a;
      w_bits      = swap ? a : y_bits;
      ex          = (x_bits[62:52] == 11'd0) ? 11'd1 : x_bits[62:52];
      ew          = (w_bits[62:52] == 11'd0) ? 11'd1 : w_bits[62:52];
      s1_sign_in  = x_bits[63];
      s1_sub_in   = x_bits[63] ^ w_bits[63];
      s1_exp_in   = ex;
      s1_dexp_in  = ex - ew;
      s1_sigx_in  = {x_bits[62:52] != 11'd0, x_bits[51:0]};
      s1_sigy_in  = {w_bits[62:52] != 11'd0, w_bits[51:0]};
      s1_nan_in   = f64_is_nan(a) || f64_is_nan(b) ||
                    (f64_is_inf(a) && f64_is_inf(b) && (a[63] ^ y_bits[63]));
      s1_inf_in   = f64_is_inf(a) || f64_is_inf(b);
      s1_isign_in = f64_is_inf(a) ? a[63] : y_bits[63];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sign_ff  <= s1_sign_in;
         s1_sub_ff   <= s1_sub_in;
         s1_exp_ff   <= s1_exp_in;
         s1_dexp_ff  <= s1_dexp_in;
         s1_sigx_ff  <= s1_sigx_in;
         s1_sigy_ff  <= s1_sigy_in;
         s1_nan_ff   <= s1_nan_in;
         s1_inf_ff   <= s1_inf_in;
         s1_isign_ff <= s1_isign_in;
      end
   end

   // stage 2: align smaller operand, add or subtract
   logic [55:0] ext_y, shifted_y, aligned_y;
   logic        sticky;
   logic [56:0] s2_sum_in;

   logic        s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_isign_ff;
   logic [10:0] s2_exp_ff;
   logic [56:0] s2_sum_ff;

   always_comb begin
      ext_y = {s1_sigy_ff, 3'b000};
      if (s1_dexp_ff >= 11'd56) begin
         shifted_y = 56'd0;
         sticky    = ext_y != 56'd0;
      end else begin
         shifted_y = ext_y >> s1_dexp_ff[5:0];
         sticky    = (shifted_y << s1_dexp_ff[5:0]) != ext_y;
      end
      aligned_y = {shifted_y[55:1], shifted_y[0] | sticky};
      if (s1_sub_ff) begin
         s2_sum_in = {1'b0, s1_sigx_ff, 3'b000} - {1'b0, aligned_y};
      end else begin
         s2_sum_in = {1'b0, s1_sigx_ff, 3'b000} + {1'b0, aligned_y};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sign_ff  <= s1_sign_ff;
         s2_exp_ff   <= s1_exp_ff;
         s2_sum_ff   <= s2_sum_in;
         s2_nan_ff   <= s1_nan_ff;
         s2_inf_ff   <= s1_inf_ff;
         s2_isign_ff <= s1_isign_ff;
      end
   end

   // stage 3: pick normalizing shift, limited by the subnormal floor
   logic [5:0]  lz;
   logic [5:0]  s3_shift_in;

   logic        s3_sign_ff, s3_nan_ff, s3_inf_ff, s3_isign_ff;
   logic [10:0] s3_exp_ff;
   logic [56:0] s3_sum_ff;
   logic [5:0]  s3_shift_ff;

   always_comb begin
      lz = lead_zeros56(s2_sum_ff[55:0]);
      if ({5'd0, lz} < (s2_exp_ff - 11'd1)) begin
         s3_shift_in = lz;
      end else begin
         s3_shift_in = 6'(s2_exp_ff - 11'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sign_ff  <= s2_sign_ff;
         s3_exp_ff   <= s2_exp_ff;
         s3_sum_ff   <= s2_sum_ff;
         s3_shift_ff <= s3_shift_in;
         s3_nan_ff   <= s2_nan_ff;
         s3_inf_ff   <= s2_inf_ff;
         s3_isign_ff <= s2_isign_ff;
      end
   end

   // stage 4: normalize, round, pack
   logic [55:0]          mant;
   logic [11:0]          exp_n;
   logic [10:0]          field;
   logic                 round_up;
   logic [62:0]          packed_mag;
   logic [WordWidth-1:0] diff_in, diff_ff;

   always_comb begin
      if (s3_sum_ff[56]) begin
         mant  = {s3_sum_ff[56:2], s3_sum_ff[1] | s3_sum_ff[0]};
         exp_n = {1'b0, s3_exp_ff} + 12'd1;
      end else begin
         mant  = s3_sum_ff[55:0] << s3_shift_ff;
         exp_n = {1'b0, s3_exp_ff} - {6'd0, s3_shift_ff};
      end
      field      = mant[55] ? exp_n[10:0] : 11'd0;
      round_up   = mant[2] & (mant[1] | mant[0] | mant[3]);
      packed_mag = {field, mant[54:3]} + {62'd0, round_up};
      if (s3_nan_ff) begin
         diff_in = QuietNan;
      end else if (s3_inf_ff) begin
         diff_in = {s3_isign_ff, 11'h7FF, 52'd0};
      end else if (exp_n >= 12'd2047) begin
         diff_in = {s3_sign_ff, 11'h7FF, 52'd0};
      end else begin
         diff_in = {s3_sign_ff, packed_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
      end
   end

   assign diff = diff_ff;

endmodule

FILE: src/afc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_scale
// Four-stage tolerance scaling: delta = tolerance * 2^e, e from the larger
// operand in frexp style, one rounding to nearest even.
// ----------------------------------------------------------------------------
module afc_scale
   import afc_pkg::*;
(
   input  logic                 clock,
   input  logic                 advance,
   input  logic [WordWidth-1:0] a,
   input  logic [WordWidth-1:0] b,
   input  logic [WordWidth-1:0] tolerance,
   output logic [WordWidth-1:0] delta
);

   function automatic logic [5:0] msb52(input logic [51:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   // stage 1: operand exponent, tolerance unpack
   logic [WordWidth-1:0] chosen;
   logic [5:0]           c_msb, t_msb;
   logic [11:0]          s1_e_in, s1_et_in;
   logic [5:0]           s1_lsh_in;
   logic [52:0]          s1_mant_in;

   logic [11:0]          s1_e_ff, s1_et_ff;
   logic [5:0]           s1_lsh_ff;
   logic [52:0]          s1_mant_ff;
   logic [WordWidth-1:0] s1_tol_ff;

   always_comb begin
      chosen = (!f64_is_nan(a) && !f64_is_nan(b) && (a[62:0] > b[62:0])) ? a : b;
      c_msb  = msb52(chosen[51:0]);
      if (chosen[62:52] == 11'h7FF) begin
         s1_e_in = 12'd0;
      end else if (chosen[62:52] != 11'd0) begin
         s1_e_in = {1'b0, chosen[62:52]} - 12'd1022;
      end else if (chosen[51:0] == 52'd0) begin
         s1_e_in = 12'd0;
      end else begin
         s1_e_in = {6'd0, c_msb} - 12'd1073;
      end

      t_msb = msb52(tolerance[51:0]);
      if (tolerance[62:52] != 11'd0) begin
         s1_et_in   = {1'b0, tolerance[62:52]} - 12'd1023;
         s1_lsh_in  = 6'd0;
         s1_mant_in = {1'b1, tolerance[51:0]};
      end else begin
         s1_et_in   = {6'd0, t_msb} - 12'd1074;
         s1_lsh_in  = 6'd52 - t_msb;
         s1_mant_in = {1'b0, tolerance[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_e_ff    <= s1_e_in;
         s1_et_ff   <= s1_et_in;
         s1_lsh_ff  <= s1_lsh_in;
         s1_mant_ff <= s1_mant_in;
         s1_tol_ff  <= tolerance;
      end
   end

   // stage 2: normalize mantissa, sum exponents
   logic signed [12:0]   s2_exp_in;
   logic signed [12:0]   s2_exp_ff;
   logic [52:0]          s2_mant_ff;
   logic [WordWidth-1:0] s2_tol_ff;

   assign s2_exp_in = $signed({s1_et_ff[11], s1_et_ff}) + $signed({s1_e_ff[11], s1_e_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_exp_ff  <= s2_exp_in;
         s2_mant_ff <= s1_mant_ff << s1_lsh_ff;
         s2_tol_ff  <= s1_tol_ff;
      end
   end

   // stage 3: special pass-through, overflow, normal or denormalizing shift
   logic signed [12:0]   sh_full;
   logic [5:0]           sh;
   logic [54:0]          ext, shifted;
   logic                 lost;
   logic [WordWidth-1:0] s3_base_in;
   logic                 s3_up_in;

   logic [WordWidth-1:0] s3_base_ff;
   logic                 s3_up_ff;

   always_comb begin
      sh_full = -13'sd1022 - s2_exp_ff;
      sh      = (sh_full > 13'sd55) ? 6'd55 : sh_full[5:0];
      ext     = {s2_mant_ff, 2'b00};
      shifted = ext >> sh;
      lost    = (shifted << sh) != ext;
      s3_up_in = 1'b0;
      if ((s2_tol_ff[62:52] == 11'h7FF) || f64_is_zero(s2_tol_ff)) begin
         s3_base_in = s2_tol_ff;
      end else if (s2_exp_ff > 13'sd1023) begin
         s3_base_in = {s2_tol_ff[63], 11'h7FF, 52'd0};
      end else if (s2_exp_ff >= -13'sd1022) begin
         s3_base_in = {s2_tol_ff[63], 11'(s2_exp_ff + 13'sd1023), s2_mant_ff[51:0]};
      end else begin
         s3_base_in = {s2_tol_ff[63], 11'd0, shifted[53:2]};
         s3_up_in   = shifted[1] & (shifted[0] | lost | shifted[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_base_ff <= s3_base_in;
         s3_up_ff   <= s3_up_in;
      end
   end

   // stage 4: apply rounding increment (a carry lands in the exponent field)
   logic [WordWidth-1:0] delta_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_ff <= {s3_base_ff[63], s3_base_ff[62:0] + {62'd0, s3_up_ff}};
      end
   end

   assign delta = delta_ff;

endmodule

FILE: src/approximate_float_compare_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approximate_float_compare_unit
// Relative-tolerance three-way compare of two binary64 values.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+------------------------------
//   req_if   | in        | valid / ready    | first_value, second_value
//   rsp_if   | out       | valid / ready    | order (+1, -1, 0)
//   csr_*    | in        | APB, pready = 1  | tolerance (64 bits, addr 0)
//
// One transaction is accepted per cycle unless the output stalls; each
// result passes the input register, four stages in the subtractor and
// scaler, and the result register. Throughput is set by that pipeline.
// A stalled result freezes the whole pipeline, so req_if.ready drops only
// while a result waits and the consumer holds ready low.
// Reset clears the stage valid bits and loads tolerance with two to the
// minus fifty-two; there is no clearing pass.
//
module approximate_float_compare_unit
   import afc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   afc_req_if.sink                 req_if,
   afc_rsp_if.source               rsp_if,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [WordWidth-1:0]    csr_pwdata,
   output logic [WordWidth-1:0]    csr_prdata,
   output logic                    csr_pready
);

   // ---------------------------------------------------------------- config
   logic [WordWidth-1:0] tolerance_ff;
   logic                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // paddr[2:0] is the byte offset inside the 8-byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= ToleranceReset;
      end else if (csr_write && (csr_paddr[3] == RegTolerance)) begin
         tolerance_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[3] == RegTolerance) ? tolerance_ff : '0;

   // ------------------------------------------------------------- pipeline
   // Advance every stage together unless a result is held at the output.
   logic advance;
   logic rsp_valid_ff;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // input register
   logic                 in_valid_ff;
   logic [WordWidth-1:0] a_ff, b_ff, tol_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff   <= req_if.first_value;
         b_ff   <= req_if.second_value;
         tol_ff <= tolerance_ff;
      end
   end

   // valid bits for the four arithmetic stages
   logic [3:0] stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         in_valid_ff    <= req_if.valid;
         stage_valid_ff <= {stage_valid_ff[2:0], in_valid_ff};
         rsp_valid_ff   <= stage_valid_ff[3];
      end
   end

   // rounded difference first - second
   logic [WordWidth-1:0] diff;

   afc_sub u_sub (
      .clock   (clock),
      .advance (advance),
      .a       (a_ff),
      .b       (b_ff),
      .diff    (diff)
   );

   // tolerance scaled to the larger operand
   logic [WordWidth-1:0] delta;

   afc_scale u_scale (
      .clock     (clock),
      .advance   (advance),
      .a         (a_ff),
      .b         (b_ff),
      .tolerance (tol_ff),
      .delta     (delta)
   );

   // ---------------------------------------------------------------- compare
   // NaN on either side fails both tests; signed zeros compare equal.
   logic [WordWidth-1:0] neg_delta;
   logic                 ordered_hi, ordered_lo;
   logic                 greater, less;
   logic signed [1:0]    order_in, order_ff;

   always_comb begin
      neg_delta  = {~delta[63], delta[62:0]};
      ordered_hi = !f64_is_nan(diff) && !f64_is_nan(delta) &&
                   !(f64_is_zero(diff) && f64_is_zero(delta));
      ordered_lo = !f64_is_nan(diff) && !f64_is_nan(delta) &&
                   !(f64_is_zero(diff) && f64_is_zero(delta));
      greater    = ordered_hi && (f64_order_key(diff) > f64_order_key(delta));
      less       = ordered_lo && (f64_order_key(diff) < f64_order_key(neg_delta));
      priority if (greater) begin
         order_in = OrderGreater;
      end else if (less) begin
         order_in = OrderLess;
      end else begin
         order_in = OrderEqual;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         order_ff <= order_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.order = order_ff;

endmodule

FILE: src/afc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks for the compare unit, bound to the top level.
// ----------------------------------------------------------------------------
module afc_checker
   import afc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [1:0] rsp_order
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_order))
      else $error("stalled result changed");

   // a held result backs up the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   // an empty output stage always lets a transaction in
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_order == OrderGreater || rsp_order == OrderLess ||
                     rsp_order == OrderEqual))
      else $error("illegal order code");

endmodule

bind approximate_float_compare_unit afc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_order (rsp_if.order)
);

FILE: verif/order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_checker
// Watches the operand, result and register ports of the compare unit,
// predicts the approximate order of every accepted pair and compares it.
// ----------------------------------------------------------------------------
module order_checker
   import afc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   afc_req_if                      req_mon,
   afc_rsp_if                      rsp_mon,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic                    csr_pready,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [WordWidth-1:0]    csr_pwdata,
   output int                      mismatch_count,
   output int                      orders_pending
);

   logic [WordWidth-1:0] tolerance_shadow;
   logic signed [1:0]    order_queue[$];

   function automatic real pow2(input int n);
      logic [63:0] pattern;
      pattern = 64'(1023 + n) << 52;
      return $bitstoreal(pattern);
   endfunction

   function automatic int frexp_exponent(input logic [63:0] v);
      int msb;
      if (v[62:52] == 11'h7FF) return 0;
      if (v[62:52] != 11'd0) return int'(v[62:52]) - 1022;
      if (v[51:0] == 52'd0) return 0;
      msb = 51;
      while (msb > 0 && !v[msb]) msb--;
      return msb - 1073;
   endfunction

   // single rounding: pre-scale only when 2^n itself is out of range
   function automatic real scale_tolerance(input real x, input int n);
      real y;
      y = x;
      if (n > 1023) begin
         y = y * pow2(1023);
         n = n - 1023;
         if (n > 1023) begin
            y = y * pow2(1023);
            n = n - 1023;
            if (n > 1023) n = 1023;
         end
      end else if (n < -1022) begin
         y = y * pow2(-969);
         n = n + 969;
         if (n < -1022) begin
            y = y * pow2(-969);
            n = n + 969;
            if (n < -1022) n = -1022;
         end
      end
      return y * pow2(n);
   endfunction

   function automatic logic signed [1:0] predict_order(input logic [63:0] a_bits,
                                                        input logic [63:0] b_bits,
                                                        input logic [63:0] tol_bits);
      real         mag_a, mag_b, delta, diff;
      logic [63:0] chosen;
      mag_a  = $bitstoreal({1'b0, a_bits[62:0]});
      mag_b  = $bitstoreal({1'b0, b_bits[62:0]});
      chosen = (mag_a > mag_b) ? a_bits : b_bits;
      delta  = scale_tolerance($bitstoreal(tol_bits), frexp_exponent(chosen));
      diff   = $bitstoreal(a_bits) - $bitstoreal(b_bits);
      if (diff > delta) return OrderGreater;
      if (diff < -delta) return OrderLess;
      return OrderEqual;
   endfunction

   assign orders_pending = order_queue.size();

   always @(posedge clock) begin
      logic signed [1:0] want;
      if (reset) begin
         tolerance_shadow <= ToleranceReset;
         order_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            order_queue.push_back(predict_order(req_mon.first_value, req_mon.second_value,
                                                tolerance_shadow));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (order_queue.size() == 0) begin
               $error("order: unexpected result %0d", rsp_mon.order);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = order_queue.pop_front();
               if (want !== rsp_mon.order) begin
                  $error("order: expected %0d actual %0d", want, rsp_mon.order);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[3] == RegTolerance)
            tolerance_shadow <= csr_pwdata;
      end
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operand pairs and tolerance settings into the compare unit under
// random back-pressure; the checker predicts and compares every order.
// ----------------------------------------------------------------------------
module testbench
   import afc_pkg::*;
();

   localparam int CycleLimit = 200000;

   logic                    clock;
   logic                    reset;
   logic                    csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [WordWidth-1:0]    csr_pwdata, csr_prdata;
   logic                    csr_pready;
   int                      mismatch_count, orders_pending;
   int                      cycle_count = 0;
   bit                      idling_on;

   afc_req_if req_ch();
   afc_rsp_if rsp_ch();

   approximate_float_compare_unit DUT (
      .clock, .reset, .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   order_checker u_checker (
      .clock, .reset, .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .mismatch_count, .orders_pending
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: drop ready about a fifth of the time while idling is on
   always @(posedge clock) begin
      rsp_ch.ready <= idling_on ? ($urandom_range(99) >= 20) : 1'b1;
   end

   // send one transaction; valid stays high across back-to-back pairs
   task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
      while (idling_on && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.first_value  <= a;
      req_ch.second_value <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold off until every order is back, then let the pipeline empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (orders_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // register writes only happen on an idle block
   task automatic write_csr(input logic [CsrAddrWidth-1:0] addr, input logic [63:0] data);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] special_value();
      logic [63:0] v;
      case ($urandom_range(7))
         0: v = 64'h0;
         1: v = 64'h7FF0_0000_0000_0000;
         2: v = {12'h7FF, 20'h0, $urandom} | 64'h1;
         3: v = {12'h000, 20'($urandom), $urandom};
         4: v = 64'h7FEF_FFFF_FFFF_FFFF;
         5: v = 64'h0000_0000_0000_0001;
         6: v = 64'h0010_0000_0000_0000;
         default: v = 64'h3FF0_0000_0000_0000;
      endcase
      v[63] = 1'($urandom_range(1));
      return v;
   endfunction

   // mostly neighbouring patterns so the tolerance window decides the order
   task automatic send_random_pair();
      logic [63:0] a, b;
      int          kind;
      kind = $urandom_range(99);
      a = random_word();
      if (kind < 15) begin
         b = random_word();
      end else if (kind < 30) begin
         a = special_value();
         b = ($urandom_range(1) != 0) ? special_value() : random_word();
      end else begin
         b = a + 64'($signed($urandom_range(16)) - 8);
         if ($urandom_range(9) == 0) b[63] = ~b[63];
         if ($urandom_range(4) == 0) begin
            a[62:52] = 11'($urandom_range(3));
            b[62:52] = a[62:52];
         end
      end
      if ($urandom_range(1) != 0) send_pair(a, b);
      else send_pair(b, a);
   endtask

   logic [63:0] tolerance_list[10];

   initial begin
      tolerance_list = '{64'h0, 64'hBCB0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                         64'h3FF0_0000_0000_0000, 64'h3F50_624D_D2F1_A9FC,
                         64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                         64'h3E80_0000_0000_0000};
      reset        <= 1'b1;
      idling_on    <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.first_value  <= '0;
      req_ch.second_value <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pairs on the reset tolerance: zeros, infinities, NaN, subnormals
      send_pair(64'h0, 64'h0);
      send_pair(64'h0, 64'h8000_0000_0000_0000);
      send_pair(64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
      send_pair(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
      send_pair(64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);
      send_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFE);
      send_pair(64'h0000_0000_0000_0001, 64'h0);
      send_pair(64'h0000_0000_0000_0002, 64'h0000_0000_0000_0001);
      send_pair(64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000);
      send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0001);
      send_pair(64'h3FF0_0000_0000_0003, 64'h3FF0_0000_0000_0000);
      send_pair(64'h3FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000);
      send_pair(64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_pair(64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000);

      // extreme tolerances exercise scaling overflow and underflow
      write_csr(4'h0, 64'h7FEF_FFFF_FFFF_FFFF);
      send_pair(64'h7FE0_0000_0000_0000, 64'h0);
      send_pair(64'h3FF0_0000_0000_0000, 64'h0);
      write_csr(4'h0, 64'h0000_0000_0000_0001);
      send_pair(64'h0010_0000_0000_0001, 64'h0010_0000_0000_0000);
      send_pair(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0002);
      // index past the register list: must leave tolerance alone
      write_csr(4'h8, 64'h3FF0_0000_0000_0000);
      send_pair(64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);

      // random phases, one tolerance per phase
      for (int phase = 0; phase < 11; phase++) begin
         if (phase < 10) write_csr(4'h0, tolerance_list[phase]);
         else write_csr(4'h0, random_word());
         for (int k = 0; k < 50; k++) begin
            idling_on <= !(phase == 4);
            send_random_pair();
            if (phase == 2 && k == 25) drain();
         end
      end

      idling_on <= 1'b1;
      drain();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
